// File: sv/sha256_byte_stream_hasher_assert.svh
// Assertion macros for the SHA-256 byte stream hasher checker.
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define SHA_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define SHA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: sv/sha_pkg.sv
// Shared types, constants and round functions of the SHA-256 hasher.
package sha_pkg;
  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  // Control handed from the sequencer to the compression core.
  typedef struct packed {
    logic start;
    logic init;
  } core_ctl_t;

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction
endpackage

// File: sv/sha_core.sv
// Compression core: message schedule memory, round loop and hash memory.
module sha_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sha_pkg::core_ctl_t ctl_i,
  input  logic               bw_en_i,
  input  logic [3:0]         bw_addr_i,
  input  logic [31:0]        bw_data_i,
  input  logic [3:0]         br_addr_i,
  output logic [31:0]        br_data_o,
  input  logic [2:0]         hr_addr_i,
  output logic [31:0]        hr_data_o,
  output logic               busy_o
);
  import sha_pkg::*;

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001, C_LOAD = 4'b0010, C_ROUND = 4'b0100, C_FOLD = 4'b1000
  } cstate_e;

  logic [31:0] buf_mem [16];
  logic [31:0] hash_mem [8];
  logic [31:0] br_q, hr_q;
  cstate_e     st_q, st_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
  logic [31:0] w_q [16];
  logic [31:0] w_new, t1, t2, s0, s1, wi;
  logic [5:0]  rnd;
  logic [2:0]  hidx;
  logic [31:0] hsum;

  assign busy_o = (st_q != C_IDLE);
  assign rnd    = cnt_q[5:0];
  assign hidx   = cnt_q[2:0];

  // Block buffer memory, written by the sequencer, read by it outside load and by the core during load.
  always_ff @(posedge clk_i) begin
    if (bw_en_i) buf_mem[bw_addr_i] <= bw_data_i;
    br_q <= buf_mem[(st_q == C_LOAD) ? cnt_q[3:0] : br_addr_i];
  end
  assign br_data_o = br_q;

  // Hash memory: rewritten at init and by the fold pass.
  always_ff @(posedge clk_i) begin
    if (ctl_i.init) begin
      for (int i = 0; i < 8; i++) hash_mem[i] <= H_INIT[i];
    end else if (st_q == C_FOLD) begin
      hash_mem[hidx] <= hsum;
    end
    hr_q <= hash_mem[hr_addr_i];
  end
  assign hr_data_o = hr_q;

  // Round datapath.
  assign s0    = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
  assign s1    = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
  assign w_new = w_q[0] + s0 + w_q[9] + s1;
  assign wi    = w_q[0];
  assign t1 = h_q + (ror(e_q, 6) ^ ror(e_q, 11) ^ ror(e_q, 25))
            + ((e_q & f_q) ^ (~e_q & g_q)) + ROUND_K[rnd] + wi;
  assign t2 = (ror(a_q, 2) ^ ror(a_q, 13) ^ ror(a_q, 22))
            + ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));

  // Fold the working word into the hash entry.
  always_comb begin
    case (hidx)
      3'd0: hsum = hash_mem[0] + a_q;
      3'd1: hsum = hash_mem[1] + b_q;
      3'd2: hsum = hash_mem[2] + c_q;
      3'd3: hsum = hash_mem[3] + d_q;
      3'd4: hsum = hash_mem[4] + e_q;
      3'd5: hsum = hash_mem[5] + f_q;
      3'd6: hsum = hash_mem[6] + g_q;
      default: hsum = hash_mem[7] + h_q;
    endcase
  end

  // Sequence load, rounds and fold.
  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    case (st_q)
      C_IDLE: begin
        if (ctl_i.start) begin
          st_d  = C_LOAD;
          cnt_d = '0;
        end
      end
      C_LOAD: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd16) begin
          st_d  = C_ROUND;
          cnt_d = '0;
        end
      end
      C_ROUND: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd63) begin
          st_d  = C_FOLD;
          cnt_d = '0;
        end
      end
      C_FOLD: begin
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd7) st_d = C_IDLE;
      end
      default: st_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= C_IDLE;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  // Working variables and schedule window.
  always_ff @(posedge clk_i) begin
    if (st_q == C_LOAD) begin
      if (cnt_q != 7'd0) begin
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
        w_q[15] <= br_q;
      end
      a_q <= hash_mem[0]; b_q <= hash_mem[1]; c_q <= hash_mem[2]; d_q <= hash_mem[3];
      e_q <= hash_mem[4]; f_q <= hash_mem[5]; g_q <= hash_mem[6]; h_q <= hash_mem[7];
    end else if (st_q == C_ROUND) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
      h_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
      d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
    end
  end
endmodule

// File: sv/sha_ctrl.sv
// Byte packer, padding sequencer and digest output stage.
module sha_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         data_byte_i,
  input  logic               has_byte_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        digest_word_o,
  output logic [2:0]         word_index_o,
  output logic               last_word_o,
  output sha_pkg::core_ctl_t ctl_o,
  output logic               bw_en_o,
  output logic [3:0]         bw_addr_o,
  output logic [31:0]        bw_data_o,
  output logic [3:0]         br_addr_o,
  input  logic [31:0]        br_data_i,
  output logic [2:0]         hr_addr_o,
  input  logic [31:0]        hr_data_i,
  input  logic               busy_i
);
  import sha_pkg::*;

  typedef enum logic [6:0] {
    S_INIT = 7'b0000001, S_IDLE = 7'b0000010, S_RD = 7'b0000100,
    S_WR = 7'b0001000, S_WAIT = 7'b0010000, S_OUTRD = 7'b0100000,
    S_OUT = 7'b1000000
  } state_e;

  state_e      st_q, st_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] total_q, total_d;
  logic [7:0]  byte_q, byte_d;
  logic        pad_q, pad_d;       // in padding phase
  logic        fin_q, fin_d;       // close message after current byte
  logic        zpad_q, zpad_d;     // zero fill runs to the block end, length goes next block
  logic        lenblk_q, lenblk_d; // block in the core holds the length field
  logic [2:0]  widx_q, widx_d;
  logic [31:0] dw_q, dw_d;
  logic        ov_q, ov_d;
  logic [63:0] bits;
  logic [5:0]  npos;
  logic [7:0]  pbyte;
  logic [4:0]  sh;
  logic        accept;

  assign bits       = total_q << 3;
  assign npos       = fill_q + 6'd1;
  assign in_stall_o = (st_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign sh         = {(2'd3 - fill_q[1:0]), 3'b000};
  assign br_addr_o  = fill_q[5:2];
  assign bw_addr_o  = fill_q[5:2];
  assign bw_data_o  = (br_data_i & ~(32'hff << sh)) | ({24'd0, byte_q} << sh);
  assign bw_en_o    = (st_q == S_WR);
  assign hr_addr_o  = widx_d;

  // Padding byte for the next fill position: zero, or a length byte from 56 on.
  always_comb begin
    if (npos >= LEN_POS && !zpad_q) pbyte = bits[{~npos[2:0], 3'b111} -: 8];
    else pbyte = 8'h00;
  end

  always_comb begin
    st_d = st_q; fill_d = fill_q; total_d = total_q; byte_d = byte_q;
    pad_d = pad_q; fin_d = fin_q; zpad_d = zpad_q; lenblk_d = lenblk_q;
    widx_d = widx_q; dw_d = dw_q; ov_d = ov_q;
    ctl_o = '0;
    case (st_q)
      S_INIT: begin
        ctl_o.init = 1'b1;
        st_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          if (has_byte_i) begin
            byte_d  = data_byte_i;
            total_d = total_q + 64'd1;
            fin_d   = last_i;
            st_d    = S_RD;
          end else if (last_i) begin
            byte_d = PAD_BYTE;
            pad_d  = 1'b1;
            zpad_d = (fill_q >= LEN_POS);
            st_d   = S_RD;
          end
        end
      end
      S_RD: st_d = S_WR;
      S_WR: begin
        fill_d = npos;
        if (fill_q == 6'd63) begin
          // Full block: hand it to the core.
          ctl_o.start = 1'b1;
          lenblk_d = pad_q && !zpad_q;
          zpad_d = 1'b0;
          st_d = S_WAIT;
        end else if (fin_q) begin
          fin_d = 1'b0; pad_d = 1'b1; byte_d = PAD_BYTE;
          zpad_d = (npos >= LEN_POS);
          st_d = S_RD;
        end else if (pad_q) begin
          byte_d = pbyte;
          st_d = S_RD;
        end else begin
          st_d = S_IDLE;
        end
      end
      S_WAIT: begin
        if (!busy_i) begin
          if (lenblk_q) begin
            lenblk_d = 1'b0;
            st_d = S_OUTRD;
          end else if (fin_q) begin
            fin_d = 1'b0; pad_d = 1'b1; byte_d = PAD_BYTE; zpad_d = 1'b0; st_d = S_RD;
          end else if (pad_q) begin
            byte_d = 8'h00;
            st_d = S_RD;
          end else begin
            st_d = S_IDLE;
          end
        end
      end
      S_OUTRD: begin
        dw_d = hr_data_i; ov_d = 1'b1; st_d = S_OUT;
      end
      S_OUT: begin
        if (!out_stall_i) begin
          ov_d = 1'b0;
          if (widx_q == 3'd7) begin
            widx_d = '0; total_d = '0; fill_d = '0; pad_d = 1'b0;
            st_d = S_INIT;
          end else begin
            widx_d = widx_q + 3'd1; st_d = S_OUTRD;
          end
        end
      end
      default: st_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_INIT; fill_q <= '0; total_q <= '0; pad_q <= 1'b0;
      fin_q <= 1'b0; zpad_q <= 1'b0; lenblk_q <= 1'b0; widx_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; fill_q <= fill_d; total_q <= total_d; pad_q <= pad_d;
      fin_q <= fin_d; zpad_q <= zpad_d; lenblk_q <= lenblk_d; widx_q <= widx_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    dw_q   <= dw_d;
  end

  assign out_valid_o   = ov_q;
  assign digest_word_o = dw_q;
  assign word_index_o  = widx_q;
  assign last_word_o   = (widx_q == 3'd7);
endmodule

// File: sv/sha256_byte_stream_hasher.sv
// Top level of the SHA-256 byte stream hasher.
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one item per handshake:
//   data_byte_i with has_byte_i, and last_i to close the message.
//   Output channel (out_valid_o / out_stall_i) gives eight items per
//   message, digest words h0..h7 with word_index_o, last_word_o on h7.
// Sequence: a plain byte takes a read, merge and write of the block
//   buffer word. A byte that fills a block then runs the core: it loads
//   the 16 block words, runs 64 rounds at one per cycle, does 8 hash
//   fold writes, and then the sequencer sees the core idle.
//   Padding runs byte by byte as a read and a write, plus one or two blocks.
//   Each digest word is read from the hash memory and held until no output
//   stall; after the eighth word the initial hash is reloaded.
// Reset: clears control, loads the initial hash in the first cycle after
//   reset, then in_stall_o drops. No clearing pass for the block buffer.
// Stall: a held digest word stays on the port; no input is taken until
//   all eight words have left, then a fresh message starts.
module sha256_byte_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);
  import sha_pkg::*;

  core_ctl_t   ctl;
  logic        bw_en, busy;
  logic [3:0]  bw_addr, br_addr;
  logic [31:0] bw_data, br_data, hr_data;
  logic [2:0]  hr_addr;

  sha_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .data_byte_i, .has_byte_i, .last_i,
    .out_valid_o, .out_stall_i, .digest_word_o, .word_index_o, .last_word_o,
    .ctl_o(ctl), .bw_en_o(bw_en), .bw_addr_o(bw_addr), .bw_data_o(bw_data),
    .br_addr_o(br_addr), .br_data_i(br_data), .hr_addr_o(hr_addr),
    .hr_data_i(hr_data), .busy_i(busy)
  );

  sha_core u_core (
    .clk_i, .rst_ni, .ctl_i(ctl), .bw_en_i(bw_en), .bw_addr_i(bw_addr),
    .bw_data_i(bw_data), .br_addr_i(br_addr), .br_data_o(br_data),
    .hr_addr_i(hr_addr), .hr_data_o(hr_data), .busy_o(busy)
  );
endmodule

// File: sv/sha_checker.sv
// Port-level checker for the SHA-256 byte stream hasher, with its bind.
`include "sha256_byte_stream_hasher_assert.svh"
module sha_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] digest_word_o,
  input logic [2:0]  word_index_o,
  input logic        last_word_o
);
  `SHA_ASSERT_IMP(a_last_idx, clk_i, rst_ni, out_valid_o, last_word_o == (word_index_o == 3'd7))
  `SHA_ASSERT_IMP(a_no_in_out, clk_i, rst_ni, out_valid_o, in_stall_o)
  `SHA_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(digest_word_o) && $stable(word_index_o))
  `SHA_ASSERT_NEXT(a_idx_step, clk_i, rst_ni, out_valid_o && !out_stall_i && !last_word_o,
    !out_valid_o && word_index_o == $past(word_index_o) + 3'd1)
endmodule

bind sha256_byte_stream_hasher sha_checker u_sha_checker (.*);
